// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file wmc_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define WMC_ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked assertion that also holds during reset
`define WMC_ASSERT(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/wmc_pkg.sv =====
// Constants and register codes of the windowed mean-change detector.
// No dependencies.
`default_nettype none
package wmc_pkg;
  localparam int CHANNELS      = 64;
  localparam int CH_BITS       = $clog2(CHANNELS);
  localparam int CIU_BITS      = $clog2(CHANNELS + 1);
  localparam int WINDOW_MAX    = 256;
  localparam int WH_BITS       = $clog2(WINDOW_MAX + 1);
  localparam int SLOT_BITS     = $clog2(2 * WINDOW_MAX);
  localparam int FULL_BITS     = WH_BITS + 1;
  localparam int HIST_AW       = CH_BITS + SLOT_BITS;
  localparam int SAMPLE_BITS   = 16;
  localparam int SUM_BITS      = SAMPLE_BITS + 8;
  localparam int SQ_BITS       = 2 * SAMPLE_BITS + 8;
  localparam int SM_BITS       = SQ_BITS + 2 * SUM_BITS;
  localparam int TT_BITS       = 2 * (SUM_BITS + 1);
  localparam int AA_BITS       = 2 * SUM_BITS;
  localparam int WS_BITS       = WH_BITS + SQ_BITS;
  localparam int LOG_IN_BITS   = TT_BITS + 2;
  localparam int LOG_K_BITS    = $clog2(LOG_IN_BITS);
  localparam int MANT_BITS     = 31;
  localparam int FRAC_BITS     = 30;
  localparam int LOG_BITS      = LOG_K_BITS + FRAC_BITS;
  localparam int LN2_BITS      = 26;
  localparam int PROD_BITS     = LOG_BITS + LN2_BITS;
  localparam int LOG_FRAC_BITS = 16;
  localparam int RND_SHIFT     = FRAC_BITS + LN2_BITS - LOG_FRAC_BITS;
  localparam logic [LN2_BITS-1:0] LN2_Q26 = 26'd46516320;
  localparam int DATA_BITS     = 32;
  localparam int CFG_BITS      = 32;
  localparam int CFG_IDX_BITS  = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_HALF = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNELS    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOG_PRIOR   = 2'd2;
  localparam logic [WH_BITS-1:0]  WINDOW_RESET   = WH_BITS'(16);
  localparam logic [CIU_BITS-1:0] CHANNELS_RESET = CIU_BITS'(1);
endpackage
`default_nettype wire

// ===== hw/rtl/wmc_if.sv =====
// Item channels of the detector: sample input and result output.
// Depends on wmc_pkg.
`default_nettype none
interface wmc_in_if;
  logic valid;
  logic ready;
  logic signed [wmc_pkg::SAMPLE_BITS-1:0] sample;
  logic [wmc_pkg::CH_BITS-1:0] channel;
  modport source (output valid, sample, channel, input ready);
  modport sink (input valid, sample, channel, output ready);
endinterface

interface wmc_out_if;
  logic valid;
  logic ready;
  logic signed [wmc_pkg::DATA_BITS-1:0] log_bf;
  logic [wmc_pkg::DATA_BITS-1:0] position;
  logic degenerate;
  modport source (output valid, log_bf, position, degenerate, input ready);
  modport sink (input valid, log_bf, position, degenerate, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/windowed_mean_change_log_bf.sv =====
// Windowed mean-change detector: sliding sums per channel, log Bayes factor per row.
// Depends on wmc_pkg and the channel interfaces in wmc_if.sv.
//
//   channel   dir  fields                          handshake
//   samples   in   sample, channel                 valid/ready
//   results   out  log_bf, position, degenerate    valid/ready
//   cfg       in   cfg_index, cfg_data             cfg_we, no stall
//
// One item at a time. An unused channel is dropped; a sum update runs ST_RD2, ST_UPD
// and ST_END. Once the window is full it also runs the products and the log unit; the
// log unit's 30-step squaring loop on one 31x31 multiplier runs twice per item. A
// degenerate channel skips the log. A row end with a result waits in ST_OUT.
// Sync reset clears control and the per-channel sum valid bits; history is not cleared.
// A result waiting in the output register holds only the next row end.
`default_nettype none
module windowed_mean_change_log_bf (
  input  wire logic clk,
  input  wire logic rst,
  wmc_in_if.sink    samples,
  wmc_out_if.source results,
  input  wire logic cfg_we,
  input  wire logic [wmc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [wmc_pkg::CFG_BITS-1:0] cfg_data
);
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD2   = 4'd1;
  localparam logic [3:0] ST_UPD   = 4'd2;
  localparam logic [3:0] ST_TT    = 4'd3;
  localparam logic [3:0] ST_AA    = 4'd4;
  localparam logic [3:0] ST_BB    = 4'd5;
  localparam logic [3:0] ST_WS    = 4'd6;
  localparam logic [3:0] ST_ND    = 4'd7;
  localparam logic [3:0] ST_NORM  = 4'd8;
  localparam logic [3:0] ST_SQR   = 4'd9;
  localparam logic [3:0] ST_LNMUL = 4'd10;
  localparam logic [3:0] ST_RND   = 4'd11;
  localparam logic [3:0] ST_END   = 4'd12;
  localparam logic [3:0] ST_OUT   = 4'd13;

  localparam int SB  = wmc_pkg::SAMPLE_BITS;
  localparam int UB  = wmc_pkg::SUM_BITS;
  localparam int QB  = wmc_pkg::SQ_BITS;
  localparam int LB  = wmc_pkg::LOG_IN_BITS;
  localparam int DB  = wmc_pkg::DATA_BITS;
  localparam int SCB = wmc_pkg::FULL_BITS + DB;
  localparam int OB  = SCB + 1;
  localparam logic signed [OB-1:0] SAT_MAX = {{(OB-DB+1){1'b0}}, {(DB-1){1'b1}}};
  localparam logic signed [OB-1:0] SAT_MIN = {{(OB-DB+1){1'b1}}, {(DB-1){1'b0}}};
  localparam logic signed [DB-1:0] MAX_RESET = {1'b1, {(DB-1){1'b0}}};

  logic [3:0] state;
  logic [wmc_pkg::WH_BITS-1:0] w;
  logic [wmc_pkg::CIU_BITS-1:0] ciu;
  logic signed [DB-1:0] prior;
  logic [wmc_pkg::SLOT_BITS-1:0] ws, partner;
  logic [DB-1:0] row_count;
  logic signed [DB-1:0] row_max;
  logic row_deg;
  logic [wmc_pkg::CHANNELS-1:0] sm_valid;
  logic sm_vld_q;

  logic [wmc_pkg::CH_BITS-1:0] c_q;
  logic signed [SB-1:0] x_q, old2_q;
  logic [2*SB-1:0] x_sq, old2_sq;

  logic signed [SB-1:0] hist_mem [0:2**wmc_pkg::HIST_AW-1];
  logic signed [SB-1:0] hist_rd;
  logic [wmc_pkg::HIST_AW-1:0] hist_raddr;
  logic [wmc_pkg::SM_BITS-1:0] sums_mem [0:wmc_pkg::CHANNELS-1];
  logic [wmc_pkg::SM_BITS-1:0] sums_rd;

  logic [QB-1:0] s_cur;
  logic signed [UB-1:0] a_cur, b_cur;
  logic [wmc_pkg::TT_BITS-1:0] p_tt;
  logic [wmc_pkg::AA_BITS-1:0] p_aa, p_bb;
  logic [wmc_pkg::WS_BITS-1:0] p_ws;

  logic [LB-1:0] lg_x, d2_q;
  logic [wmc_pkg::LOG_K_BITS-1:0] lg_z, lg_k;
  logic [2:0] lg_step;
  logic [wmc_pkg::MANT_BITS-1:0] lg_m;
  logic [wmc_pkg::FRAC_BITS-1:0] lg_frac;
  logic [4:0] lg_iter;
  logic lg_second;
  logic [wmc_pkg::LOG_BITS-1:0] ln_n, ln_d;
  logic [wmc_pkg::PROD_BITS-1:0] prod;
  logic prod_neg;
  logic signed [SCB-1:0] scale_q;
  logic [DB-1:0] pos_q;
  logic deg_q;

  logic [wmc_pkg::FULL_BITS-1:0] full;
  logic r_ge_full, r_ge_w, r1_ge_full, in_acc, in_use, last_ch;
  logic [wmc_pkg::FULL_BITS-1:0] part_sum;
  logic [QB-1:0] s_old, s_new;
  logic signed [UB-1:0] a_old, b_old, a_new, b_new, oldw_ext, old2_ext, x_ext;
  logic signed [SB-1:0] oldw;
  logic signed [UB:0] t_sum;
  logic signed [LB-1:0] n_val, d_val;
  logic [LB-1:0] norm_x;
  logic [wmc_pkg::LOG_K_BITS-1:0] norm_sh;
  logic [2*wmc_pkg::MANT_BITS-1:0] sq_full;
  logic [wmc_pkg::MANT_BITS:0] sq_top;
  logic [wmc_pkg::MANT_BITS-1:0] m_next;
  logic [wmc_pkg::FRAC_BITS-1:0] frac_next;
  logic [wmc_pkg::LOG_BITS:0] ln_diff;
  logic [wmc_pkg::LOG_BITS-1:0] ln_mag;
  logic [wmc_pkg::PROD_BITS:0] rnd_sum;
  logic signed [DB-1:0] v_ln;
  logic signed [OB-1:0] out_sum;
  logic [wmc_pkg::WH_BITS-1:0] cfg_w;
  logic [wmc_pkg::CIU_BITS-1:0] cfg_c;
  logic out_free;

  assign full       = {w, 1'b0};
  assign r_ge_full  = row_count >= DB'(full);
  assign r_ge_w     = row_count >= DB'(w);
  assign r1_ge_full = ({1'b0, row_count} + (DB+1)'(1)) >= (DB+1)'(full);
  assign samples.ready = (state == ST_IDLE);
  assign in_acc     = samples.valid && samples.ready;
  assign in_use     = {1'b0, samples.channel} < ciu;
  assign last_ch    = {1'b0, c_q} == (ciu - wmc_pkg::CIU_BITS'(1));
  assign part_sum   = {1'b0, ws} + {1'b0, w};
  assign out_free   = !results.valid || results.ready;

  // history ring: one write, one registered read
  assign hist_raddr = (state == ST_RD2) ? {c_q, partner} : {samples.channel, ws};
  always_ff @(posedge clk) begin
    if (state == ST_UPD) hist_mem[{c_q, ws}] <= x_q;
    hist_rd <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPD) sums_mem[c_q] <= {s_new, a_new, b_new};
    if (in_acc) sums_rd <= sums_mem[samples.channel];
  end

  always_comb begin
    s_old    = sm_vld_q ? sums_rd[wmc_pkg::SM_BITS-1 -: QB] : '0;
    a_old    = sm_vld_q ? $signed(sums_rd[2*UB-1 -: UB]) : '0;
    b_old    = sm_vld_q ? $signed(sums_rd[UB-1:0]) : '0;
    oldw     = r_ge_w ? hist_rd : '0;
    oldw_ext = {{(UB-SB){oldw[SB-1]}}, oldw};
    old2_ext = {{(UB-SB){old2_q[SB-1]}}, old2_q};
    x_ext    = {{(UB-SB){x_q[SB-1]}}, x_q};
    s_new    = s_old + QB'(x_sq) - QB'(old2_sq);
    a_new    = a_old + oldw_ext - old2_ext;
    b_new    = b_old + x_ext - oldw_ext;
    t_sum    = {a_cur[UB-1], a_cur} + {b_cur[UB-1], b_cur};
    n_val    = $signed((LB'(p_ws) << 1) - LB'(p_tt));
    d_val    = $signed(LB'(p_ws) - LB'(p_aa) - LB'(p_bb));
  end

  // normalizing step of the log unit, one binary step per cycle
  always_comb begin
    norm_x  = lg_x;
    norm_sh = '0;
    unique case (lg_step)
      3'd0: if (lg_x[LB-1 -: 32] == '0) begin norm_x = lg_x << 32; norm_sh = 6'd32; end
      3'd1: if (lg_x[LB-1 -: 16] == '0) begin norm_x = lg_x << 16; norm_sh = 6'd16; end
      3'd2: if (lg_x[LB-1 -: 8] == '0) begin norm_x = lg_x << 8; norm_sh = 6'd8; end
      3'd3: if (lg_x[LB-1 -: 4] == '0) begin norm_x = lg_x << 4; norm_sh = 6'd4; end
      3'd4: if (lg_x[LB-1 -: 2] == '0) begin norm_x = lg_x << 2; norm_sh = 6'd2; end
      3'd5: if (!lg_x[LB-1]) begin norm_x = lg_x << 1; norm_sh = 6'd1; end
      default: ;
    endcase
  end

  always_comb begin
    sq_full = (2*wmc_pkg::MANT_BITS)'(lg_m) * (2*wmc_pkg::MANT_BITS)'(lg_m);
    sq_top  = sq_full[2*wmc_pkg::MANT_BITS-1 -: wmc_pkg::MANT_BITS+1];
    m_next  = sq_top[wmc_pkg::MANT_BITS] ? sq_top[wmc_pkg::MANT_BITS:1]
                                         : sq_top[wmc_pkg::MANT_BITS-1:0];
    frac_next = {lg_frac[wmc_pkg::FRAC_BITS-2:0], sq_top[wmc_pkg::MANT_BITS]};
    ln_diff = {1'b0, ln_n} - {1'b0, ln_d};
    ln_mag  = ln_diff[wmc_pkg::LOG_BITS] ? wmc_pkg::LOG_BITS'(-ln_diff)
                                         : ln_diff[wmc_pkg::LOG_BITS-1:0];
    rnd_sum = {1'b0, prod} + ((wmc_pkg::PROD_BITS+1)'(1) << (wmc_pkg::RND_SHIFT - 1));
    v_ln    = prod_neg ? -DB'(rnd_sum[wmc_pkg::PROD_BITS:wmc_pkg::RND_SHIFT])
                       : DB'(rnd_sum[wmc_pkg::PROD_BITS:wmc_pkg::RND_SHIFT]);
    out_sum = OB'(prior) + OB'(scale_q);
    cfg_w   = cfg_data[wmc_pkg::WH_BITS-1:0];
    if (cfg_w == '0) cfg_w = wmc_pkg::WH_BITS'(1);
    if (cfg_w > wmc_pkg::WH_BITS'(wmc_pkg::WINDOW_MAX)) cfg_w = wmc_pkg::WH_BITS'(wmc_pkg::WINDOW_MAX);
    cfg_c   = cfg_data[wmc_pkg::CIU_BITS-1:0];
    if (cfg_c == '0) cfg_c = wmc_pkg::CIU_BITS'(1);
    if (cfg_c > wmc_pkg::CIU_BITS'(wmc_pkg::CHANNELS)) cfg_c = wmc_pkg::CIU_BITS'(wmc_pkg::CHANNELS);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        c_q  <= samples.channel;
        x_q  <= samples.sample;
        x_sq <= (2*SB)'(samples.sample * samples.sample);
        partner <= (part_sum >= full) ? wmc_pkg::SLOT_BITS'(part_sum - full)
                                      : wmc_pkg::SLOT_BITS'(part_sum);
      end
      ST_RD2: begin
        old2_q  <= r_ge_full ? hist_rd : '0;
        old2_sq <= r_ge_full ? (2*SB)'(hist_rd * hist_rd) : '0;
      end
      ST_UPD: begin
        s_cur <= s_new;
        a_cur <= a_new;
        b_cur <= b_new;
      end
      ST_TT: p_tt <= wmc_pkg::TT_BITS'(t_sum * t_sum);
      ST_AA: p_aa <= wmc_pkg::AA_BITS'(a_cur * a_cur);
      ST_BB: p_bb <= wmc_pkg::AA_BITS'(b_cur * b_cur);
      ST_WS: p_ws <= wmc_pkg::WS_BITS'(w) * wmc_pkg::WS_BITS'(s_cur);
      ST_ND: begin
        lg_x <= LB'(n_val);
        d2_q <= LB'(d_val) << 1;
        lg_z <= '0;
        lg_step <= '0;
        lg_second <= 1'b0;
      end
      ST_NORM: begin
        lg_x <= norm_x;
        lg_z <= lg_z + norm_sh;
        lg_step <= lg_step + 3'd1;
        lg_m <= norm_x[LB-1 -: wmc_pkg::MANT_BITS];
        lg_k <= wmc_pkg::LOG_K_BITS'(LB - 1) - (lg_z + norm_sh);
        lg_frac <= '0;
        lg_iter <= '0;
      end
      ST_SQR: begin
        lg_m <= m_next;
        lg_frac <= frac_next;
        lg_iter <= lg_iter + 5'd1;
        if (lg_iter == 5'(wmc_pkg::FRAC_BITS - 1)) begin
          if (!lg_second) begin
            ln_n <= {lg_k, frac_next};
            lg_x <= d2_q;
            lg_z <= '0;
            lg_step <= '0;
            lg_second <= 1'b1;
          end else begin
            ln_d <= {lg_k, frac_next};
          end
        end
      end
      ST_LNMUL: begin
        prod <= wmc_pkg::PROD_BITS'(ln_mag) * wmc_pkg::PROD_BITS'(wmc_pkg::LN2_Q26);
        prod_neg <= ln_diff[wmc_pkg::LOG_BITS];
      end
      ST_END: begin
        scale_q <= SCB'($signed({1'b0, w}) * row_max);
        pos_q <= DB'(({1'b0, row_count} + (DB+1)'(1)) - (DB+1)'(full));
        deg_q <= row_deg;
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      w <= wmc_pkg::WINDOW_RESET;
      ciu <= wmc_pkg::CHANNELS_RESET;
      prior <= '0;
      ws <= '0;
      row_count <= '0;
      row_max <= MAX_RESET;
      row_deg <= 1'b0;
      sm_valid <= '0;
      sm_vld_q <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && state != ST_OUT) results.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          sm_vld_q <= sm_valid[samples.channel];
          if (in_acc && in_use) state <= ST_RD2;
          if (cfg_we) begin
            unique case (cfg_index)
              wmc_pkg::CFG_WINDOW_HALF: begin
                w <= cfg_w;
                sm_valid <= '0;
                row_count <= '0;
                row_max <= MAX_RESET;
                row_deg <= 1'b0;
                ws <= '0;
              end
              wmc_pkg::CFG_CHANNELS: ciu <= cfg_c;
              wmc_pkg::CFG_LOG_PRIOR: prior <= $signed(cfg_data);
              default: ;
            endcase
          end
        end
        ST_RD2: state <= ST_UPD;
        ST_UPD: begin
          sm_valid[c_q] <= 1'b1;
          state <= r1_ge_full ? ST_TT : ST_END;
        end
        ST_TT: state <= ST_AA;
        ST_AA: state <= ST_BB;
        ST_BB: state <= ST_WS;
        ST_WS: state <= ST_ND;
        ST_ND: begin
          if (n_val <= 0 || d_val <= 0) begin
            row_deg <= 1'b1;
            state <= ST_END;
          end else begin
            state <= ST_NORM;
          end
        end
        ST_NORM: if (lg_step == 3'd5) state <= ST_SQR;
        ST_SQR: begin
          if (lg_iter == 5'(wmc_pkg::FRAC_BITS - 1))
            state <= lg_second ? ST_LNMUL : ST_NORM;
        end
        ST_LNMUL: state <= ST_RND;
        ST_RND: begin
          if (v_ln > row_max) row_max <= v_ln;
          state <= ST_END;
        end
        ST_END: begin
          if (last_ch) begin
            row_max <= MAX_RESET;
            row_deg <= 1'b0;
            if (row_count != '1) row_count <= row_count + DB'(1);
            ws <= ({1'b0, ws} + wmc_pkg::FULL_BITS'(1) == full) ? '0
                                                                : ws + wmc_pkg::SLOT_BITS'(1);
            state <= r1_ge_full ? ST_OUT : ST_IDLE;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            results.valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      results.log_bf <= (out_sum > SAT_MAX) ? DB'(SAT_MAX)
                      : (out_sum < SAT_MIN) ? DB'(SAT_MIN) : DB'(out_sum);
      results.position <= pos_q;
      results.degenerate <= deg_q;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/wmc_checker.sv =====
// Port-level checks on the detector's result channel.
// Depends on assert_macros.svh and the channel interfaces; bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module wmc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);
  `WMC_ASSERT_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)
  `WMC_ASSERT(a_rst_clear, clk, $past(rst) |-> !out_valid)
  `WMC_ASSERT_RST(a_no_fast_result, clk, rst, $rose(out_valid) |-> !$past(in_valid && in_ready))
endmodule

bind windowed_mean_change_log_bf wmc_checker u_wmc_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(samples.valid),
  .in_ready(samples.ready),
  .out_valid(results.valid),
  .out_ready(results.ready)
);
`default_nettype wire

// ===== tb/sv/tb_windowed_mean_change_log_bf.sv =====
// Testbench for windowed_mean_change_log_bf: directed table, then random rows per phase.
// Depends on wmc_pkg and the channel interfaces in wmc_if.sv.
`timescale 1ns / 1ps
module tb_windowed_mean_change_log_bf;

  typedef struct packed {
    logic signed [31:0] log_bf;
    logic [31:0] position;
    logic degenerate;
  } bf_result_t;

  typedef struct {
    bit is_cfg;
    logic [wmc_pkg::CFG_IDX_BITS-1:0] idx;
    logic [31:0] data;
    logic signed [15:0] sample;
    logic [5:0] ch;
    bit typed;
    bf_result_t want;
  } dir_row_t;

  localparam bf_result_t NO_RES = '0;
  localparam bf_result_t ALL_DEGEN = '{32'sh8000_0000, 32'd0, 1'b1};
  localparam int LIMIT = 1000000;
  localparam int N_DIR = 28;

  logic clk = 0;
  logic rst;
  logic cfg_we;
  logic [wmc_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [wmc_pkg::CFG_BITS-1:0] cfg_data;

  wmc_in_if in_ch ();
  wmc_out_if out_ch ();

  windowed_mean_change_log_bf DUT (
    .clk(clk), .rst(rst), .samples(in_ch), .results(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state
  int win_half, chans;
  logic signed [31:0] prior;
  shortint hist [64][512];
  logic [39:0] sq_sum [64];
  logic signed [23:0] left_acc [64];
  logic signed [23:0] right_acc [64];
  longint unsigned rows_done;
  longint row_peak;
  bit row_degen;
  int slot;

  bf_result_t bf_expected [$];
  int fails = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  function automatic longint unsigned log2_q30(longint unsigned x);
    int k;
    longint unsigned m, frac;
    k = 63;
    frac = 0;
    while (k > 0 && !x[k]) k--;
    m = (k >= 30) ? (x >> (k - 30)) : (x << (30 - k));
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(k) << 30) + frac;
  endfunction

  function automatic longint ln_ratio(longint unsigned num, longint unsigned den);
    longint diff, prod;
    longint unsigned mag;
    diff = longint'(log2_q30(num)) - longint'(log2_q30(den));
    prod = diff * 64'sd46516320;
    mag = prod < 0 ? longint'(-prod) : prod;
    mag = (mag + (64'd1 << 39)) >> 40;
    return prod < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic void restart_stream();
    for (int c = 0; c < 64; c++) begin
      sq_sum[c] = '0;
      left_acc[c] = '0;
      right_acc[c] = '0;
    end
    rows_done = 0;
    row_peak = -64'sd2147483648;
    row_degen = 0;
    slot = 0;
  endfunction

  function automatic void apply_reg(logic [wmc_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] v);
    int n;
    if (idx == wmc_pkg::CFG_WINDOW_HALF) begin
      n = v[8:0];
      win_half = n < 1 ? 1 : (n > wmc_pkg::WINDOW_MAX ? wmc_pkg::WINDOW_MAX : n);
      restart_stream();
    end else if (idx == wmc_pkg::CFG_CHANNELS) begin
      n = v[6:0];
      chans = n < 1 ? 1 : (n > wmc_pkg::CHANNELS ? wmc_pkg::CHANNELS : n);
    end else if (idx == wmc_pkg::CFG_LOG_PRIOR) begin
      prior = v;
    end
  endfunction

  function automatic bit predict_row(logic signed [15:0] x, logic [5:0] ch,
                                     output bf_result_t res);
    longint xs, old2, oldw, s, a, b, n, d, v, t;
    int full, partner;
    bit emit;
    res = NO_RES;
    if (ch >= chans) return 0;
    xs = x;
    full = 2 * win_half;
    partner = (slot + win_half) % full;
    old2 = rows_done >= full ? longint'(hist[ch][slot]) : 0;
    oldw = rows_done >= win_half ? longint'(hist[ch][partner]) : 0;
    sq_sum[ch] = 40'(longint'(sq_sum[ch]) + xs * xs - old2 * old2);
    left_acc[ch] = 24'(longint'(left_acc[ch]) + oldw - old2);
    right_acc[ch] = 24'(longint'(right_acc[ch]) + xs - oldw);
    hist[ch][slot] = x;
    emit = (rows_done + 1 >= full);
    if (emit) begin
      s = longint'(sq_sum[ch]);
      a = left_acc[ch];
      b = right_acc[ch];
      n = longint'(full) * s - (a + b) * (a + b);
      d = longint'(win_half) * s - a * a - b * b;
      if (n <= 0 || d <= 0) row_degen = 1;
      else begin
        v = ln_ratio(n, 2 * d);
        if (v > row_peak) row_peak = v;
      end
    end
    if (ch != chans - 1) return 0;
    if (emit) begin
      t = longint'(prior) + longint'(win_half) * row_peak;
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      res.log_bf = t[31:0];
      res.position = 32'(rows_done + 1 - full);
      res.degenerate = row_degen;
    end
    row_peak = -64'sd2147483648;
    row_degen = 0;
    if (rows_done != 64'hFFFF_FFFF) rows_done++;
    slot = (slot + 1) % full;
    return emit;
  endfunction

  task automatic drain();
    in_ch.valid <= 0;
    while (bf_expected.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [wmc_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] v);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    apply_reg(idx, v);
  endtask

  task automatic push_sample(logic signed [15:0] x, logic [5:0] ch, bit typed,
                             bf_result_t want);
    bf_result_t pred;
    bit emit;
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.sample <= x;
    in_ch.channel <= ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    emit = predict_row(x, ch, pred);
    if (emit) bf_expected.push_back(typed ? want : pred);
  endtask

  function automatic logic signed [15:0] pick_sample(int mode);
    int r;
    r = $urandom_range(99);
    if (r < 5) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    if (mode == 1 || r < 30) return 16'($signed($urandom_range(6)) - 3);
    return 16'($urandom);
  endfunction

  task automatic run_phase(int wh, int nch, logic [31:0] pr, int idle, int stall,
                           int rows, int mode, bit pause);
    int order [64];
    int j, tmp;
    write_reg(wmc_pkg::CFG_CHANNELS, nch);
    write_reg(wmc_pkg::CFG_LOG_PRIOR, pr);
    write_reg(wmc_pkg::CFG_WINDOW_HALF, wh);
    idle_pct = idle;
    stall_pct = stall;
    for (int r = 0; r < rows; r++) begin
      if (pause && r == rows / 2) drain();
      for (int i = 0; i < chans; i++) order[i] = i;
      if (chans > 2 && $urandom_range(99) < 15) begin
        for (int i = chans - 2; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
      end
      for (int i = 0; i < chans; i++) begin
        if (chans < 64 && $urandom_range(99) < 5)
          push_sample(16'($urandom), 6'($urandom_range(63, chans)), 0, NO_RES);
        push_sample(pick_sample(mode), 6'(order[i]), 0, NO_RES);
      end
    end
  endtask

  dir_row_t dir_tab [N_DIR] = '{
    '{1, wmc_pkg::CFG_WINDOW_HALF, 32'd0, 16'sd0, 6'd0, 0, NO_RES},
    '{1, wmc_pkg::CFG_CHANNELS, 32'd0, 16'sd0, 6'd0, 0, NO_RES},
    '{1, wmc_pkg::CFG_LOG_PRIOR, 32'd0, 16'sd0, 6'd0, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, 16'sd5, 6'd0, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, 16'sd5, 6'd0, 1, ALL_DEGEN},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, 16'sd7, 6'd9, 0, NO_RES},
    '{1, wmc_pkg::CFG_WINDOW_HALF, 32'd1, 16'sd0, 6'd0, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, -16'sd32768, 6'd0, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, 16'sd32767, 6'd0, 1, ALL_DEGEN},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, 16'sd32767, 6'd0, 0, NO_RES},
    '{1, wmc_pkg::CFG_CHANNELS, 32'd3, 16'sd0, 6'd0, 0, NO_RES},
    '{1, wmc_pkg::CFG_LOG_PRIOR, 32'h8000_0000, 16'sd0, 6'd0, 0, NO_RES},
    '{1, wmc_pkg::CFG_WINDOW_HALF, 32'd2, 16'sd0, 6'd0, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, 16'sd100, 6'd0, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, -16'sd5, 6'd1, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, 16'sd32767, 6'd2, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, 16'sd0, 6'd1, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, -16'sd200, 6'd0, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, -16'sd32768, 6'd2, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, 16'sd50, 6'd0, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, 16'sd1, 6'd63, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, 16'sd7, 6'd1, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, 16'sd1, 6'd2, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, -16'sd50, 6'd0, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, 16'sd9, 6'd1, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, 16'sd2, 6'd2, 0, NO_RES},
    '{1, wmc_pkg::CFG_LOG_PRIOR, 32'd0, 16'sd0, 6'd0, 0, NO_RES},
    '{0, wmc_pkg::CFG_WINDOW_HALF, 32'd0, 16'sd32767, 6'd0, 0, NO_RES}
  };

  initial begin
    out_ch.ready = 0;
    in_ch.valid = 0;
    in_ch.sample = 0;
    in_ch.channel = 0;
    cfg_we = 0;
    cfg_index = wmc_pkg::CFG_WINDOW_HALF;
    cfg_data = 0;
    rst = 1;
    win_half = 16;
    chans = 1;
    prior = 0;
    restart_stream();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].idx, dir_tab[i].data);
      else push_sample(dir_tab[i].sample, dir_tab[i].ch, dir_tab[i].typed, dir_tab[i].want);
    end

    run_phase(4, 1, 32'd0, 0, 0, 60, 0, 0);
    run_phase(3, 8, -32'sd196608, 51, 0, 20, 0, 1);
    run_phase(2, 100, 32'h8000_0000, 0, 51, 5, 0, 0);
    run_phase(1, 5, -32'sd100000, 8, 8, 20, 1, 0);
    run_phase(8, 2, -32'sd12345, 51, 51, 40, 1, 0);
    run_phase(511, 1, 32'd0, 0, 0, 530, 0, 0);

    drain();
    repeat (200) @(posedge clk);
    if (fails == 0) $display("PASS windowed_mean_change_log_bf");
    else $display("FAIL windowed_mean_change_log_bf");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) out_ch.ready <= 0;
    else out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    bf_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (bf_expected.size() == 0) begin
        $error("unexpected result log_bf=%0d position=%0d", out_ch.log_bf, out_ch.position);
        fails++;
      end else begin
        want = bf_expected.pop_front();
        if (out_ch.log_bf !== want.log_bf) begin
          $error("log_bf expected %0d actual %0d", want.log_bf, out_ch.log_bf);
          fails++;
        end
        if (out_ch.position !== want.position) begin
          $error("position expected %0d actual %0d", want.position, out_ch.position);
          fails++;
        end
        if (out_ch.degenerate !== want.degenerate) begin
          $error("degenerate expected %0d actual %0d", want.degenerate, out_ch.degenerate);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL windowed_mean_change_log_bf");
      $finish;
    end
  end
endmodule
